// ===== src/xsr256p_pkg.sv =====
// Shared types and constants for the xoshiro256+ generator unit.
package xsr256p_pkg;

	localparam int unsigned WORD_W      = 64;
	localparam int unsigned NUM_WORDS   = 4;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SHIFT_AMT   = 17;
	localparam int unsigned ROT_AMT     = 45;
	localparam int unsigned BYTE_POS    = 40;
	localparam int unsigned DIV_CNT_W   = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] SEED_RESET [NUM_WORDS] = '{
		64'd1, 64'd0, 64'd0, 64'd0
	};

	typedef enum logic [1:0] {
		OP_RAW          = 2'd0,
		OP_BOUNDED      = 2'd1,
		OP_BYTE         = 2'd2,
		OP_BOUNDED_BYTE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ===== src/xsr256p_divider.sv =====
// Bit-serial restoring divider that yields the remainder of a 64-bit division.
module xsr256p_divider
	import xsr256p_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic [WORD_W-1:0] remainder
);

	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W:0]   diff;

	// One quotient bit per cycle while step is high: shift in the next dividend bit and subtract if it fits.
	always_comb begin
		rem_shift = {rem_q, dvd_q[WORD_W-1]};
		diff      = rem_shift - {1'b0, dsr_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= diff[WORD_W] ? rem_shift[WORD_W-1:0] : diff[WORD_W-1:0];
		end
	end

	assign remainder = rem_q;

endmodule

// ===== src/xsr256p_dpath.sv =====
// Datapath: generator state, operand registers, remainder unit and output word register.
module xsr256p_dpath
	import xsr256p_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [1:0]             op,
	input  logic [WORD_W-1:0]      range_low,
	input  logic [WORD_W-1:0]      range_high,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [WORD_W-1:0]      random_value
);

	logic [WORD_W-1:0]    gen_q [NUM_WORDS];
	logic [WORD_W-1:0]    gen_d [NUM_WORDS];
	logic [WORD_W-1:0]    sum;
	logic [WORD_W-1:0]    t_shift;
	logic [WORD_W-1:0]    mix3;
	logic [WORD_W-1:0]    value_q;
	logic [WORD_W-1:0]    offset_q;
	logic                 empty_q;
	logic                 need_div_q;
	op_t                  op_q;
	op_t                  op_in;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    dividend;
	logic [WORD_W-1:0]    divisor;
	logic                 empty;
	logic                 need_div;
	logic [WORD_W-1:0]    offset;
	logic [WORD_W-1:0]    remainder;
	logic [WORD_W-1:0]    result;
	logic [BYTE_W-1:0]    lo8;
	logic [BYTE_W-1:0]    hi8;
	logic [BYTE_W:0]      span8;
	logic [WORD_W-1:0]    span64;
	logic [WORD_W-1:0]    out_q;
	logic                 out_valid_q;
	logic                 out_load;

	assign op_in = op_t'(op);
	assign lo8   = range_low[BYTE_W-1:0];
	assign hi8   = range_high[BYTE_W-1:0];

	// xoshiro256+ advance: output is word 0 plus word 3, then xor, shift and rotate mixing.
	always_comb begin
		sum      = gen_q[0] + gen_q[3];
		t_shift  = gen_q[1] << SHIFT_AMT;
		mix3     = gen_q[3] ^ gen_q[1];
		gen_d[2] = gen_q[2] ^ gen_q[0] ^ t_shift;
		gen_d[1] = gen_q[1] ^ gen_q[2] ^ gen_q[0];
		gen_d[0] = gen_q[0] ^ mix3;
		gen_d[3] = {mix3[WORD_W-ROT_AMT-1:0], mix3[WORD_W-1:WORD_W-ROT_AMT]};
	end

	// Operand setup for the requested mode.
	always_comb begin
		span64   = range_high - range_low + 64'd1;
		span8    = {1'b0, hi8} - {1'b0, lo8} + 9'd1;
		dividend = sum;
		divisor  = 64'd1;
		empty    = 1'b0;
		offset   = '0;
		case (op_in)
			OP_BOUNDED: begin
				empty   = !(range_high > range_low);
				divisor = (span64 == '0) ? 64'd1 : span64;
				offset  = range_low;
			end
			OP_BOUNDED_BYTE: begin
				empty    = !(hi8 > lo8);
				dividend = {{(WORD_W-BYTE_W){1'b0}}, sum[BYTE_POS +: BYTE_W]};
				divisor  = {{(WORD_W-BYTE_W-1){1'b0}}, span8};
				offset   = {{(WORD_W-BYTE_W){1'b0}}, lo8};
			end
			default: begin
				empty = 1'b0;
			end
		endcase
		need_div = (op_in inside {OP_BOUNDED, OP_BOUNDED_BYTE}) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				gen_q[i] <= SEED_RESET[i];
			end
		end else if (cfg_we) begin
			gen_q[cfg_index] <= cfg_data;
		end else if (cmd.start) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				gen_q[i] <= gen_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_q <= 1'b0;
			cnt_q      <= '0;
		end else if (cmd.start) begin
			need_div_q <= need_div;
			cnt_q      <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q  <= sum;
			offset_q <= offset;
			empty_q  <= empty;
			op_q     <= op_in;
		end
	end

	xsr256p_divider u_divider (
		.clk       (clk),
		.load      (cmd.start),
		.step      (cmd.div_step),
		.dividend  (dividend),
		.divisor   (divisor),
		.remainder (remainder)
	);

	always_comb begin
		case (op_q)
			OP_RAW:  result = value_q;
			OP_BYTE: result = {{(WORD_W-BYTE_W){1'b0}}, value_q[BYTE_POS +: BYTE_W]};
			default: result = empty_q ? '0 : remainder + offset_q;
		endcase
	end

	// Output word register lets the next request start while a word waits.
	assign out_load = cmd.load_out && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign random_value    = out_q;
	assign status.need_div = need_div_q;
	assign status.div_last = (cnt_q == DIV_CNT_W'(WORD_W - 1));
	assign status.out_free = !out_valid_q || out_ready;

endmodule

// ===== src/xsr256p_ctrl.sv =====
// Controller state machine sequencing request acceptance, division and result hand-off.
module xsr256p_ctrl
	import xsr256p_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !cfg_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.need_div || status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cfg_ready    = 1'b0;
		cmd.start    = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				cmd.start = in_valid && !cfg_valid;
			end
			ST_DIV: begin
				cmd.div_step = status.need_div;
			end
			ST_FINISH: begin
				cmd.load_out = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/xoshiro256plus_generator_unit.sv =====
// Top level of the xoshiro256+ random generator unit.
//
// This unit keeps four 64-bit xoshiro256+ state words and advances them once for every
// request word accepted on the input channel, returning one result word per request. The
// op field selects raw 64-bit output (word 0 plus word 3), a byte taken from bits 47..40 of
// that sum, or a bounded form of either, which returns the value modulo (high - low + 1)
// plus low when high is greater than low and zero otherwise; a 64-bit range that spans
// every value gives low. The state resets to words 1, 0, 0, 0, and writing configuration
// register i (i from 0 to 3) loads state word i directly; software seeds the generator this
// way and should write configuration only while no request is in flight. A raw or byte
// request goes from the division state, which it leaves at once, to the finishing state
// that loads its result into the output register; a bounded request stays in the division
// state while a bit-serial restoring divider forms one remainder bit per cycle over all
// 64 dividend bits, and then loads its result in the finishing state. One request is
// processed at a time, and a finished result word sits in an output register so that the
// next request can be accepted while it waits to be taken; a request that finishes while
// that register is still full waits until the receiver takes the older word.
module xoshiro256plus_generator_unit
	import xsr256p_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [WORD_W-1:0]      range_low,
	input  logic [WORD_W-1:0]      range_high,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [WORD_W-1:0]      random_value,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data
);

	cmd_t    cmd;
	status_t status;

	// The controller only sequences; all words and arithmetic live in the datapath.
	xsr256p_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// A configuration write takes precedence over a request in the same cycle.
	xsr256p_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (op),
		.range_low    (range_low),
		.range_high   (range_high),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.random_value (random_value)
	);

endmodule
